### design/asd_pkg.sv
package asd_pkg;

	// sample geometry
	localparam int SAMPLE_BITS = 16;
	localparam int AXIS_W      = 16;
	localparam int TIME_W      = 32;
	localparam int COUNT_W     = 32;
	localparam int MAG_W       = 16;

	// square and root widths follow from the sample width
	localparam int SQ1_W     = 2 * SAMPLE_BITS;
	localparam int ROOT_BITS = SAMPLE_BITS + 1;
	localparam int SQ_W      = 2 * ROOT_BITS;
	localparam int ITER_W    = $clog2(ROOT_BITS);

	// configuration port
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_RISE     = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SETTLE   = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = CFG_IDX_W'(2);

	localparam logic [CFG_W-1:0] RESET_RISE     = CFG_W'(307);
	localparam logic [CFG_W-1:0] RESET_SETTLE   = CFG_W'(102);
	localparam logic [CFG_W-1:0] RESET_INTERVAL = CFG_W'(300);

	// queue between front and back
	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [SQ_W-1:0]   sum_sq;
		logic [TIME_W-1:0] time_ms;
	} asd_work_t;

	typedef struct packed {
		logic [CFG_W-1:0] rise_threshold;
		logic [CFG_W-1:0] settle_threshold;
		logic [CFG_W-1:0] min_interval_ms;
	} asd_cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROOT,
		ST_DONE
	} asd_state_t;

endpackage

### design/asd_if.sv
interface asd_sample_if;
	import asd_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [AXIS_W-1:0] accel_x;
	logic signed [AXIS_W-1:0] accel_y;
	logic signed [AXIS_W-1:0] accel_z;
	logic [TIME_W-1:0]        time_ms;

	modport source (output valid, output accel_x, output accel_y, output accel_z,
		output time_ms, input ready);
	modport sink (input valid, input accel_x, input accel_y, input accel_z,
		input time_ms, output ready);
endinterface

interface asd_result_if;
	import asd_pkg::*;

	logic               valid;
	logic               ready;
	logic [COUNT_W-1:0] steps_total;
	logic               step_now;
	logic [MAG_W-1:0]   magnitude;

	modport source (output valid, output steps_total, output step_now, output magnitude,
		input ready);
	modport sink (input valid, input steps_total, input step_now, input magnitude,
		output ready);
endinterface

### design/asd_front.sv
module asd_front import asd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	asd_sample_if.sink   sample,
	output asd_work_t    work,
	output logic         work_valid,
	input  logic         work_ready
);

	logic                   v_s1;
	logic                   v_s2;
	logic                   adv_s1;
	logic                   adv_s2;
	logic [SAMPLE_BITS-1:0] abs_x_s1;
	logic [SAMPLE_BITS-1:0] abs_y_s1;
	logic [SAMPLE_BITS-1:0] abs_z_s1;
	logic [TIME_W-1:0]      time_s1;
	logic [SQ1_W-1:0]       sq_x_s2;
	logic [SQ1_W-1:0]       sq_y_s2;
	logic [SQ1_W-1:0]       sq_z_s2;
	logic [TIME_W-1:0]      time_s2;

	// axis taken from its low bits as two's complement, then made absolute
	function automatic logic [SAMPLE_BITS-1:0] axis_abs(input logic [AXIS_W-1:0] raw);
		logic [SAMPLE_BITS-1:0] v;
		v = SAMPLE_BITS'(raw);
		return v[SAMPLE_BITS-1] ? (SAMPLE_BITS'(0) - v) : v;
	endfunction

	// stage enables: a stage moves when it is empty or its successor moves
	assign adv_s2       = !v_s2 || work_ready;
	assign adv_s1       = !v_s1 || adv_s2;
	assign sample.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= sample.valid;
			if (adv_s2) v_s2 <= v_s1;
		end
	end

	// stage 1: absolute values
	always_ff @(posedge clk) begin
		if (adv_s1 && sample.valid) begin
			abs_x_s1 <= axis_abs(sample.accel_x);
			abs_y_s1 <= axis_abs(sample.accel_y);
			abs_z_s1 <= axis_abs(sample.accel_z);
			time_s1  <= sample.time_ms;
		end
	end

	// stage 2: one square per axis
	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			sq_x_s2 <= SQ1_W'(abs_x_s1) * SQ1_W'(abs_x_s1);
			sq_y_s2 <= SQ1_W'(abs_y_s1) * SQ1_W'(abs_y_s1);
			sq_z_s2 <= SQ1_W'(abs_z_s1) * SQ1_W'(abs_z_s1);
			time_s2 <= time_s1;
		end
	end

	// sum of squares into the queue
	assign work.sum_sq  = SQ_W'(sq_x_s2) + SQ_W'(sq_y_s2) + SQ_W'(sq_z_s2);
	assign work.time_ms = time_s2;
	assign work_valid   = v_s2;

endmodule

### design/asd_queue.sv
module asd_queue import asd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	output logic      push_ready,
	input  asd_work_t push_data,
	output logic      pop_valid,
	input  logic      pop_ready,
	output asd_work_t pop_data
);

	asd_work_t         mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != QCNT_W'(QDEPTH));
	assign pop_valid  = (count_q != QCNT_W'(0));
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_data;
	end

endmodule

### design/asd_back.sv
module asd_back import asd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  asd_cfg_t      cfg,
	input  logic          q_valid,
	output logic          q_pop,
	input  asd_work_t     q_data,
	asd_result_if.source  result
);

	asd_state_t          state_q;
	asd_state_t          state_d;
	logic                start;
	logic                load;
	logic [ITER_W-1:0]   iter_q;
	logic [SQ_W-1:0]     rem_q;
	logic [SQ_W-1:0]     res_q;
	logic [SQ_W-1:0]     bit_q;
	logic [SQ_W-1:0]     trial;
	logic                take;
	logic [TIME_W-1:0]   time_q;

	logic [MAG_W-1:0]    prev_mag_q;
	logic [TIME_W-1:0]   last_step_q;
	logic [COUNT_W-1:0]  step_total_q;
	logic                disarmed_q;

	logic [MAG_W-1:0]    mag;
	logic [MAG_W-1:0]    change;
	logic [TIME_W-1:0]   elapsed;
	logic                fire;
	logic                disarmed_d;

	logic                out_valid_q;
	logic [COUNT_W-1:0]  out_steps_q;
	logic                out_step_q;
	logic [MAG_W-1:0]    out_mag_q;

	// sequencer: pull a sum, run the root, hand off to the output register
	always_comb begin
		state_d = state_q;
		start   = 1'b0;
		load    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					start   = 1'b1;
					state_d = ST_ROOT;
				end
			end
			ST_ROOT: begin
				if (iter_q == ITER_W'(ROOT_BITS - 1)) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || result.ready) begin
					load = 1'b1;
					if (q_valid) begin
						start   = 1'b1;
						state_d = ST_ROOT;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign q_pop = start;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			iter_q  <= '0;
		end else begin
			state_q <= state_d;
			if (start)                  iter_q <= '0;
			else if (state_q == ST_ROOT) iter_q <= iter_q + 1'b1;
		end
	end

	// bit-pair square root, one result bit per cycle
	assign trial = res_q + bit_q;
	assign take  = (rem_q >= trial);

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= q_data.sum_sq;
			res_q  <= '0;
			bit_q  <= SQ_W'(1) << (SQ_W - 2);
			time_q <= q_data.time_ms;
		end else if (state_q == ST_ROOT) begin
			if (take) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	// step decision on the finished root
	always_comb begin
		mag     = (|res_q[SQ_W-1:MAG_W]) ? {MAG_W{1'b1}} : res_q[MAG_W-1:0];
		change  = (mag >= prev_mag_q) ? (mag - prev_mag_q) : (prev_mag_q - mag);
		elapsed = time_q - last_step_q;
		fire    = (change > cfg.rise_threshold) &&
			(elapsed > TIME_W'(cfg.min_interval_ms)) && !disarmed_q;
		disarmed_d = fire ? 1'b1 : disarmed_q;
		if (change < cfg.settle_threshold) disarmed_d = 1'b0;
	end

	// detector state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_mag_q   <= '0;
			last_step_q  <= '0;
			step_total_q <= '0;
			disarmed_q   <= 1'b0;
		end else if (load) begin
			prev_mag_q <= mag;
			disarmed_q <= disarmed_d;
			if (fire) begin
				step_total_q <= step_total_q + 1'b1;
				last_step_q  <= time_q;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_steps_q <= fire ? step_total_q + 1'b1 : step_total_q;
			out_step_q  <= fire;
			out_mag_q   <= mag;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.steps_total = out_steps_q;
	assign result.step_now    = out_step_q;
	assign result.magnitude   = out_mag_q;

	// checks
	a_iter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROOT) |-> (iter_q <= ITER_W'(ROOT_BITS - 1)))
		else $error("root iteration count out of range");

	a_pop_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (q_valid && (state_q == ST_IDLE || state_q == ST_DONE)))
		else $error("queue popped while root busy");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (out_valid_q && out_steps_q == step_total_q))
		else $error("result register does not match step count");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(load && fire) |=> (step_total_q == $past(step_total_q) + 1'b1 && disarmed_q ==
		$past(disarmed_d)))
		else $error("step not counted");

endmodule

### design/accel_step_detector_core.sv
// Magnitude-threshold step detector. Each accepted sample (three signed axes at
// 1/1024 g and a millisecond timestamp) yields exactly one result: the running
// step count, a flag for a step on this sample, and the truncated magnitude
// sqrt(x*x + y*y + z*z). A front pipeline takes the absolute values and squares in
// two stages and feeds a two-entry queue; the back end runs a bit-pair square root
// that retires one result bit per cycle, then decides the step and loads the output
// register once that register is free. The root unit works on one sum at a time and
// pulls the next only after the previous result is loaded. Thresholds must be
// written through the cfg port while no sample is in flight; the block itself
// does not enforce this. Index 0 is the rise threshold, 1 the settle threshold,
// 2 the minimum step interval in ms; other indexes are ignored.
module accel_step_detector_core import asd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	asd_sample_if.sink           sample,
	asd_result_if.source         result
);

	asd_cfg_t  cfg_q;
	asd_work_t work;
	logic      work_valid;
	logic      work_ready;
	asd_work_t q_data;
	logic      q_valid;
	logic      q_pop;

	// threshold registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rise_threshold   <= RESET_RISE;
			cfg_q.settle_threshold <= RESET_SETTLE;
			cfg_q.min_interval_ms  <= RESET_INTERVAL;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RISE:     cfg_q.rise_threshold   <= cfg_data;
				REG_SETTLE:   cfg_q.settle_threshold <= cfg_data;
				REG_INTERVAL: cfg_q.min_interval_ms  <= cfg_data;
				default:      cfg_q                  <= cfg_q;
			endcase
		end
	end

	asd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample     (sample),
		.work       (work),
		.work_valid (work_valid),
		.work_ready (work_ready)
	);

	asd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (work_valid),
		.push_ready (work_ready),
		.push_data  (work),
		.pop_valid  (q_valid),
		.pop_ready  (q_pop),
		.pop_data   (q_data)
	);

	asd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.q_data  (q_data),
		.result  (result)
	);

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import asd_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;

	// index with no register behind it
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);

	typedef struct {
		logic [COUNT_W-1:0] steps_total;
		logic               step_now;
		logic [MAG_W-1:0]   magnitude;
	} step_result_t;

	typedef struct {
		logic signed [AXIS_W-1:0] x;
		logic signed [AXIS_W-1:0] y;
		logic signed [AXIS_W-1:0] z;
		logic [TIME_W-1:0]        t;
	} accel_sample_t;

	// pedometer state tracking and result checking
	class step_scoreboard;
		logic [CFG_W-1:0]   rise;
		logic [CFG_W-1:0]   settle;
		logic [CFG_W-1:0]   interval;
		logic [MAG_W-1:0]   last_mag;
		logic [TIME_W-1:0]  last_step_at;
		logic [COUNT_W-1:0] step_count;
		logic               idle_lock;
		step_result_t       due_results[$];
		int                 errors;

		function new();
			rise         = RESET_RISE;
			settle       = RESET_SETTLE;
			interval     = RESET_INTERVAL;
			last_mag     = '0;
			last_step_at = '0;
			step_count   = '0;
			idle_lock    = 1'b0;
			errors       = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			case (idx)
				REG_RISE:     rise = val;
				REG_SETTLE:   settle = val;
				REG_INTERVAL: interval = val;
				default: ;
			endcase
		endfunction

		// magnitude of one axis, taken as a SAMPLE_BITS-wide signed value
		function logic [63:0] axis_mag(logic [AXIS_W-1:0] raw);
			logic [63:0] mask;
			logic [63:0] v;
			mask = (64'd1 << SAMPLE_BITS) - 64'd1;
			v = 64'(raw) & mask;
			if (v[SAMPLE_BITS-1])
				v = (mask + 64'd1) - v;
			return v;
		endfunction

		function void take_sample(accel_sample_t s);
			logic [63:0]        ax, ay, az;
			logic [63:0]        sum, root, trial;
			logic [MAG_W-1:0]   mag, change;
			logic [TIME_W-1:0]  elapsed;
			step_result_t       res;
			ax = axis_mag(s.x);
			ay = axis_mag(s.y);
			az = axis_mag(s.z);
			sum = ax * ax + ay * ay + az * az;
			// floor root, one result bit at a time from the top
			root = '0;
			for (int b = 31; b >= 0; b--) begin
				trial = root | (64'd1 << b);
				if (trial * trial <= sum)
					root = trial;
			end
			mag = (root > 64'hFFFF) ? 16'hFFFF : root[MAG_W-1:0];
			change = (mag >= last_mag) ? mag - last_mag : last_mag - mag;
			elapsed = s.t - last_step_at;
			res.step_now = 1'b0;
			if (change > rise && elapsed > TIME_W'(interval) && !idle_lock) begin
				step_count   = step_count + 1'b1;
				last_step_at = s.t;
				idle_lock    = 1'b1;
				res.step_now = 1'b1;
			end
			// re-arm test runs after the step test on the same beat
			if (change < settle)
				idle_lock = 1'b0;
			last_mag = mag;
			res.steps_total = step_count;
			res.magnitude   = mag;
			due_results.push_back(res);
		endfunction

		function void check_result(logic [COUNT_W-1:0] steps_total, logic step_now,
				logic [MAG_W-1:0] magnitude);
			step_result_t want;
			if (due_results.size() == 0) begin
				$error("result beat with no expectation pending");
				errors++;
				return;
			end
			want = due_results.pop_front();
			if (want.steps_total !== steps_total) begin
				$error("steps_total: expected %0d, got %0d", want.steps_total, steps_total);
				errors++;
			end
			if (want.step_now !== step_now) begin
				$error("step_now: expected %0b, got %0b", want.step_now, step_now);
				errors++;
			end
			if (want.magnitude !== magnitude) begin
				$error("magnitude: expected %0d, got %0d", want.magnitude, magnitude);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	asd_sample_if sample_ch();
	asd_result_if result_ch();

	step_scoreboard sb = new();

	logic [TIME_W-1:0] stamp_ms;
	logic              calm;
	logic              at_peak;
	int                cycle_count = 0;

	accel_step_detector_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample_ch),
		.result    (result_ch)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// gap length: mostly none, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// result side: random stalls
	initial begin
		int hold;
		hold = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
				hold = pick_gap();
			end
		end
	end

	// check every accepted result beat
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready)
			sb.check_result(result_ch.steps_total, result_ch.step_now, result_ch.magnitude);
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// one sample beat; valid stays high when the next beat follows at once
	task automatic push_sample(accel_sample_t s);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid   <= 1'b1;
		sample_ch.accel_x <= s.x;
		sample_ch.accel_y <= s.y;
		sample_ch.accel_z <= s.z;
		sample_ch.time_ms <= s.t;
		do @(posedge clk); while (!sample_ch.ready);
		sb.take_sample(s);
	endtask

	// stop sending and wait for every pending result
	task automatic wait_idle();
		sample_ch.valid <= 1'b0;
		while (sb.due_results.size() != 0)
			@(posedge clk);
	endtask

	// write all thresholds plus the unused index, block idle
	task automatic load_regs(logic [CFG_W-1:0] rise, logic [CFG_W-1:0] settle,
			logic [CFG_W-1:0] interval);
		logic [CFG_IDX_W-1:0] idx [4];
		logic [CFG_W-1:0]     val [4];
		idx = '{REG_RISE, REG_SETTLE, REG_INTERVAL, REG_SPARE};
		val = '{rise, settle, interval, CFG_W'($urandom)};
		for (int k = 0; k < 4; k++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[k];
			cfg_data  <= val[k];
			@(posedge clk);
			sb.write_reg(idx[k], val[k]);
		end
		cfg_we <= 1'b0;
	endtask

	// edge cases at reset thresholds (rise 307, settle 102, interval 300)
	task automatic send_directed();
		accel_sample_t plan [21];
		plan = '{
			'{16'h0000, 16'h0000, 16'h0000, 32'd0},
			'{16'h0133, 16'h0000, 16'h0000, 32'd1000},     // change equals rise
			'{16'h0000, 16'h0000, 16'h0000, 32'd1010},
			'{16'h0000, 16'h0000, 16'h0400, 32'd1020},     // step
			'{16'h0000, 16'h0000, 16'h0000, 32'd2000},     // disarmed
			'{16'h0000, 16'h0000, 16'h0066, 32'd2010},     // change equals settle
			'{16'h0000, 16'h0000, 16'h0065, 32'd2020},     // re-arm
			'{16'h0000, 16'h0000, 16'h0400, 32'd1320},     // interval exactly min
			'{16'h0000, 16'h0000, 16'h0000, 32'd1321},     // step
			'{16'h0000, 16'h0000, 16'h0000, 32'd2330},
			'{16'h8000, 16'h8000, 16'h8000, 32'd2400},     // most negative axes
			'{16'h7FFF, 16'h8000, 16'h0000, 32'hFFFF_FFF0},
			'{16'hFFFF, 16'h0001, 16'hFFFF, 32'h0000_0005}, // interval wraps
			'{16'h0000, 16'h0000, 16'h0001, 32'h0000_0006},
			'{16'h0000, 16'h0000, 16'h0C00, 32'h0000_0400},
			'{16'h0000, 16'h0000, 16'h0000, 32'h0000_0402},
			'{16'h0000, 16'h0000, 16'h0000, 32'h0000_0403},
			'{16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h0000_0100}, // time runs backwards
			'{16'h8000, 16'h7FFF, 16'hFFFF, 32'h0000_0101},
			'{16'h0000, 16'h0000, 16'h0000, 32'hFFFF_FFFF},
			'{16'h0001, 16'hFFFF, 16'h0000, 32'h8000_0000}
		};
		foreach (plan[i])
			push_sample(plan[i]);
	endtask

	// walking-like magnitude swings with some rest and some noise
	task automatic send_activity(int count);
		accel_sample_t s;
		int r;
		int level;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 10) begin
				s.x = AXIS_W'($urandom);
				s.y = AXIS_W'($urandom);
				s.z = AXIS_W'($urandom);
				if ($urandom_range(0, 1))
					stamp_ms = $urandom;
				else
					stamp_ms = stamp_ms - $urandom_range(1, 2000);
			end else begin
				if (r < 22) begin
					level = 1024 + $urandom_range(0, 8);
				end else begin
					if ($urandom_range(0, 3) != 0)
						at_peak = ~at_peak;
					level = at_peak ? 1024 + $urandom_range(0, 1500)
					                : 1024 - $urandom_range(0, 300);
				end
				s.x = AXIS_W'($urandom_range(0, 128)) - AXIS_W'(64);
				s.y = AXIS_W'($urandom_range(0, 128)) - AXIS_W'(64);
				s.z = AXIS_W'(level);
				if ($urandom_range(0, 7) == 0)
					s.z = -s.z;
				stamp_ms = stamp_ms + $urandom_range(5, 400);
			end
			s.t = stamp_ms;
			push_sample(s);
		end
	endtask

	// main sequence
	initial begin
		logic [CFG_W-1:0] rise;
		arst_n            <= 1'b0;
		cfg_we            <= 1'b0;
		cfg_index         <= '0;
		cfg_data          <= '0;
		sample_ch.valid   <= 1'b0;
		sample_ch.accel_x <= '0;
		sample_ch.accel_y <= '0;
		sample_ch.accel_z <= '0;
		sample_ch.time_ms <= '0;
		calm     = 1'b0;
		at_peak  = 1'b0;
		stamp_ms = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset thresholds
		send_directed();
		wait_idle();

		// lowest settings, timestamps about to wrap
		load_regs(16'h0000, 16'h0000, 16'h0000);
		stamp_ms = 32'hFFFF_F000;
		send_activity(150);
		wait_idle();

		// highest settings, never steps
		load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_activity(100);
		wait_idle();

		// settle above rise, re-arms right after a step
		calm = 1'b1;
		load_regs(16'd200, 16'd900, 16'd50);
		send_activity(150);
		wait_idle();

		// random settings, a sender pause halfway through each
		for (int ph = 0; ph < 5; ph++) begin
			calm = ($urandom_range(0, 3) == 0);
			rise = CFG_W'($urandom_range(50, 1500));
			load_regs(rise, CFG_W'($urandom_range(0, 2 * rise)),
				CFG_W'($urandom_range(0, 600)));
			send_activity(80);
			wait_idle();
			send_activity(80);
			wait_idle();
		end

		// let any stray beat show up
		repeat (30) @(posedge clk);
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
